// ===== hdl/half_float_xor_delta_decoder_core_macros.svh =====
// Assertion macros used by the XOR delta decoder top level.
// No dependencies; included by files that carry concurrent checks.
`ifndef HALF_FLOAT_XOR_DELTA_DECODER_CORE_MACROS_SVH
`define HALF_FLOAT_XOR_DELTA_DECODER_CORE_MACROS_SVH

// Check a consequence in the same cycle
`define HFXD_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("hfxd same-cycle check failed");

// Check a consequence in the following cycle
`define HFXD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("hfxd next-cycle check failed");

`endif

// ===== hdl/hfxd_pkg.sv =====
// Types, codes and float conversion functions for the XOR delta decoder.
// No dependencies; imported by the decoder top level (hfxd_ram does not use it).
package hfxd_pkg;

    localparam logic [1:0] CMD_SEED  = 2'd0;
    localparam logic [1:0] CMD_DELTA = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam int          BYTE_BITS          = 8;
    localparam logic [2:0]  REG_ACTIVE_LEN_ADDR = 3'd0;
    localparam logic [8:0]  ACTIVE_LEN_RESET   = 9'd256;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  element_index;
        logic [31:0] seed_bits;
        logic [7:0]  delta_lo;
        logic [7:0]  delta_hi;
    } item_t;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        status;
    } result_t;

    // Round single precision to half: nearest-even, overflow to infinity, quiet NaN
    function automatic logic [15:0] single_to_half(logic [31:0] x);
        logic               s;
        logic [7:0]         ex;
        logic [22:0]        man;
        logic signed [9:0]  e;
        logic [23:0]        m;
        logic [4:0]         sh;
        logic [23:0]        h24;
        logic [23:0]        rem;
        logic [23:0]        hw;
        logic [14:0]        h15;
        logic [15:0]        res;
        s   = x[31];
        ex  = x[30:23];
        man = x[22:0];
        e   = $signed({2'b00, ex}) - 10'sd112;
        m   = {1'b1, man};
        sh  = 5'(10'sd14 - e);
        h24 = m >> sh;
        rem = m & ((24'd1 << sh) - 24'd1);
        hw  = 24'd1 << (sh - 5'd1);
        h15 = {e[4:0], man[22:13]};
        if (ex == 8'hff) begin
            if (man != 23'd0)
                res = {s, 5'h1f, 1'b1, man[21:13]};
            else
                res = {s, 15'h7c00};
        end
        else if (e >= 10'sd31) begin
            res = {s, 15'h7c00};
        end
        else if (e <= 10'sd0) begin
            if (e < -10'sd10)
                res = {s, 15'd0};
            else if (rem > hw || (rem == hw && h24[0]))
                res = {s, h24[14:0] + 15'd1};
            else
                res = {s, h24[14:0]};
        end
        else begin
            if (man[12:0] > 13'h1000 || (man[12:0] == 13'h1000 && h15[0]))
                res = {s, h15 + 15'd1};
            else
                res = {s, h15};
        end
        return res;
    endfunction

    // Widen half to single exactly; subnormals are normalized
    function automatic logic [31:0] half_to_single(logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  m;
        logic [3:0]  pos;
        logic [9:0]  mn;
        logic [7:0]  e;
        logic [31:0] res;
        ex  = h[14:10];
        m   = h[9:0];
        pos = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i])
                pos = 4'(i);
        end
        mn = m << (4'd10 - pos);
        e  = 8'd103 + {4'd0, pos};
        if (ex == 5'd0) begin
            if (m == 10'd0)
                res = {h[15], 31'd0};
            else
                res = {h[15], e, mn, 13'd0};
        end
        else if (ex == 5'h1f) begin
            res = {h[15], 8'hff, m, 13'd0};
        end
        else begin
            res = {h[15], 8'({3'd0, ex} + 8'd112), m, 13'd0};
        end
        return res;
    endfunction

endpackage

// ===== hdl/hfxd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the previous snapshot for the decoder.
module hfxd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read, old data on a collision
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/half_float_xor_delta_decoder_core.sv =====
// Top level of the half-float XOR delta decoder: four-stage pipeline and APB register.
// Depends on hfxd_pkg, hfxd_ram and half_float_xor_delta_decoder_core_macros.svh.
//
//   channel | direction | handshake                 | payload
//   item    | in        | item_valid / item_stall   | hfxd_pkg::item_t
//   result  | out       | result_valid / result_stall | hfxd_pkg::result_t
//   apb     | in/out    | psel, penable, pready     | paddr, pwdata, prdata
//
// One item per cycle unless a result stall backs up to item_stall.
// Stages: store read and seed capture, rounding and forwarding, update and
// write back, widening into the output register. Stalls back up stage by stage,
// so bubbles fill while the output waits. Reset clears valid bits and sets
// active_len to 256; the store is not cleared and needs no clearing pass.
`include "half_float_xor_delta_decoder_core_macros.svh"
module half_float_xor_delta_decoder_core #(
    parameter int MAX_VALUES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_stall,
    input  hfxd_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_stall,
    output hfxd_pkg::result_t  result
);

    import hfxd_pkg::*;

    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

    logic [8:0]   active_len_reg;

    // stage A
    logic         va_reg;
    logic [1:0]   cmda_reg;
    logic [7:0]   idxa_reg;
    logic         oka_reg;
    logic [31:0]  seeda_reg;
    logic [15:0]  deltaa_reg;
    // stage B
    logic         vb_reg;
    logic [1:0]   cmdb_reg;
    logic [7:0]   idxb_reg;
    logic         okb_reg;
    logic [15:0]  oldb_reg;
    logic [15:0]  seedhb_reg;
    logic [15:0]  deltab_reg;
    // stage C
    logic         vc_reg;
    logic [7:0]   idxc_reg;
    logic         okc_reg;
    logic [15:0]  halfc_reg;
    // output stage
    logic         vd_reg;
    result_t      result_reg;

    logic         adv_a, adv_b, adv_c, adv_d;
    logic         accept;
    logic         in_ok;
    logic [7:0]   rd_idx;
    logic [AW+7:0] rd_ext;
    logic [AW+7:0] wr_ext;
    logic [15:0]  rdata;
    logic [15:0]  olda;
    logic [15:0]  newb;
    logic         ram_we;
    result_t      result_next;

    // Per-stage advance, back to front
    assign adv_d      = !vd_reg || !result_stall;
    assign adv_c      = !vc_reg || adv_d;
    assign adv_b      = !vb_reg || adv_c;
    assign adv_a      = !va_reg || adv_b;
    assign item_stall = !adv_a;
    assign accept     = item_valid && adv_a;

    // Range check against the active length and the store depth
    assign in_ok = (9'(item.element_index) < active_len_reg)
                && (32'(item.element_index) < 32'(MAX_VALUES));

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_ACTIVE_LEN_ADDR) ? {23'd0, active_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_len_reg <= ACTIVE_LEN_RESET;
        else if (psel && penable && pwrite && pready && paddr == REG_ACTIVE_LEN_ADDR)
            active_len_reg <= pwdata[8:0];
    end

    // Re-read the entry of whatever sits in stage A next cycle
    assign rd_idx = adv_a ? item.element_index : idxa_reg;
    assign rd_ext = {{AW{1'b0}}, rd_idx};
    assign wr_ext = {{AW{1'b0}}, idxb_reg};
    assign ram_we = vb_reg && okb_reg && adv_c;

    hfxd_ram #(
        .WIDTH (16),
        .DEPTH (MAX_VALUES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ext[AW-1:0]),
        .wdata (newb),
        .raddr (rd_ext[AW-1:0]),
        .rdata (rdata)
    );

    // Forward writes the store read has not seen yet
    always_comb
    begin
        if (vb_reg && okb_reg && idxb_reg == idxa_reg)
            olda = newb;
        else if (vc_reg && okc_reg && idxc_reg == idxa_reg)
            olda = halfc_reg;
        else
            olda = rdata;
    end

    // Build the updated entry
    always_comb
    begin
        unique case (cmdb_reg)
            CMD_SEED:  newb = seedhb_reg;
            CMD_DELTA: newb = oldb_reg ^ deltab_reg;
            default:   newb = oldb_reg;
        endcase
    end

    // Widen into the output payload
    always_comb
    begin
        result_next.value_bits = okc_reg ? half_to_single(halfc_reg) : 32'd0;
        result_next.status     = !okc_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                va_reg <= item_valid;
            if (adv_b)
                vb_reg <= va_reg;
            if (adv_c)
                vc_reg <= vb_reg;
            if (adv_d)
                vd_reg <= vc_reg;
        end
    end

    // Payload stages, held while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmda_reg   <= item.cmd;
            idxa_reg   <= item.element_index;
            oka_reg    <= in_ok;
            seeda_reg  <= item.seed_bits;
            deltaa_reg <= {item.delta_hi, item.delta_lo};
        end
        if (adv_b)
        begin
            cmdb_reg   <= cmda_reg;
            idxb_reg   <= idxa_reg;
            okb_reg    <= oka_reg;
            oldb_reg   <= olda;
            seedhb_reg <= single_to_half(seeda_reg);
            deltab_reg <= deltaa_reg;
        end
        if (adv_c)
        begin
            idxc_reg  <= idxb_reg;
            okc_reg   <= okb_reg;
            halfc_reg <= newb;
        end
        if (adv_d)
            result_reg <= result_next;
    end

    assign result_valid = vd_reg;
    assign result       = result_reg;

    `HFXD_ASSERT_SAME(a_flag_zero, clk, rst_n, result_valid && result.status, result.value_bits == 32'd0)
    `HFXD_ASSERT_NEXT(a_range_flag, clk, rst_n, accept && (9'(item.element_index) >= active_len_reg), va_reg && !oka_reg)
    `HFXD_ASSERT_NEXT(a_c_hold, clk, rst_n, vc_reg && !adv_c, vc_reg && $stable(halfc_reg))
    `HFXD_ASSERT_SAME(a_write_ok, clk, rst_n, ram_we, vb_reg && okb_reg && adv_b)

endmodule
